@@ sv/ktt_pkg.sv @@
// ----------------------------------------------------------------------------
// Kernel tick timer bank package
// Shared widths, command, result and register codes, and the cell status type.
// ----------------------------------------------------------------------------
package ktt_pkg;

    localparam int NUM_SEMS  = 8;
    localparam int NUM_TASKS = 8;
    localparam int NUM_CELLS = NUM_SEMS + NUM_TASKS;

    localparam int CMD_W    = 2;
    localparam int CHAN_W   = 3;
    localparam int COUNT_W  = 15;
    localparam int VALUE_W  = 16;
    localparam int MILLIS_W = 32;
    localparam int TSIZE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // input commands
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ARM_SEM  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ARM_TASK = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SIGNAL  = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_REPLY   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_SIZE = 2'd1;

    localparam logic [VALUE_W-1:0] TIMED_OUT = 16'hFFFF;

    typedef struct packed {
        logic               tok;
        logic               fire;
        logic [VALUE_W-1:0] value;
    } t_cell_stat;

endpackage

@@ sv/ktt_in_if.sv @@
// ----------------------------------------------------------------------------
// Kernel tick timer bank input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface ktt_in_if;
    logic                         valid;
    logic                         ready;
    logic [ktt_pkg::CMD_W-1:0]    cmd;
    logic [ktt_pkg::CHAN_W-1:0]   channel;
    logic [ktt_pkg::COUNT_W-1:0]  count;
    logic [ktt_pkg::COUNT_W-1:0]  reload;

    modport source (output valid, cmd, channel, count, reload, input ready);
    modport sink   (input valid, cmd, channel, count, reload, output ready);
endinterface

@@ sv/ktt_out_if.sv @@
// ----------------------------------------------------------------------------
// Kernel tick timer bank output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ktt_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          kind;
    logic [ktt_pkg::CHAN_W-1:0]          event_channel;
    logic signed [ktt_pkg::VALUE_W-1:0]  timer_value;
    logic [ktt_pkg::MILLIS_W-1:0]        millis;
    logic                                last;

    modport source (output valid, kind, event_channel, timer_value, millis, last,
                    input ready);
    modport sink   (input valid, kind, event_channel, timer_value, millis, last,
                    output ready);
endinterface

@@ sv/ktt_cell.sv @@
// ----------------------------------------------------------------------------
// Timer cell
// One countdown timer of the chain. Counts down when the walk token passes
// through it and hands the token to the next cell.
// ----------------------------------------------------------------------------
module ktt_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_tok,
    input  logic                          i_is_task,
    input  logic                          i_arm,
    input  logic [ktt_pkg::COUNT_W-1:0]   i_count,
    input  logic [ktt_pkg::COUNT_W-1:0]   i_reload,
    output ktt_pkg::t_cell_stat           o_stat
);

    logic                          r_tok;
    logic [ktt_pkg::VALUE_W-1:0]   r_val;
    logic [ktt_pkg::COUNT_W-1:0]   r_reload;
    logic [ktt_pkg::VALUE_W-1:0]   n_val;
    logic [ktt_pkg::VALUE_W-1:0]   dec;
    logic                          active;
    logic                          step;
    logic                          fire;

    always_comb begin
        active = (r_val != '0) && !r_val[ktt_pkg::VALUE_W-1];
        dec    = r_val - 16'd1;
        step   = r_tok & i_adv;
        fire   = step & active & (dec == '0);
        n_val  = r_val;
        if (i_arm) begin
            n_val = {1'b0, i_count};
        end else if (step && active) begin
            if (fire) begin
                // expired: semaphore reloads, task is marked timed out
                n_val = i_is_task ? ktt_pkg::TIMED_OUT : {1'b0, r_reload};
            end else begin
                n_val = dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
            r_val <= '0;
        end else begin
            if (i_adv) begin
                r_tok <= i_tok;
            end
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_arm) begin
            r_reload <= i_reload;
        end
    end

    assign o_stat.tok   = r_tok;
    assign o_stat.fire  = fire;
    assign o_stat.value = r_val;

endmodule

@@ sv/kernel_tick_timer_bank.sv @@
// ----------------------------------------------------------------------------
// Kernel tick timer bank
// Millisecond counter plus a chain of semaphore and task countdown cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries commands: tick, arm semaphore timer, arm task timer, read
//   task timer. o_out carries results; the final result of each command has
//   last set. The user must write configuration (running, tick_size) through
//   i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle; the
//   block does not enforce this. Arm and read commands give one reply,
//   registered on the accepting edge. A tick while running passes a token
//   down the chain of NUM_SEMS + NUM_TASKS cells, one cell per cycle while
//   the receiver keeps up, gives a signal or timeout result (last clear)
//   for each cell that expires, then emits the tick-done result and
//   returns to idle. A tick while stopped gives tick-done at once,
//   registered on the accepting edge. Results sit in one output register;
//   while the receiver stalls, the walk holds and no new command is taken.
//   Reset (synchronous, active low) clears all timers, the counter and the
//   walk; running resets to 0 and tick_size to 1.
// ----------------------------------------------------------------------------
module kernel_tick_timer_bank (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ktt_in_if.sink                            i_in,
    ktt_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [ktt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ktt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                              r_state;
    logic                              r_running;
    logic [ktt_pkg::TSIZE_W-1:0]       r_tick_size;
    logic [ktt_pkg::MILLIS_W-1:0]      r_millis;
    logic                              r_tail;

    logic                              r_out_valid;
    logic [1:0]                        r_kind;
    logic [ktt_pkg::CHAN_W-1:0]        r_chan;
    logic [ktt_pkg::VALUE_W-1:0]       r_value;
    logic                              r_last;

    ktt_pkg::t_cell_stat               stat [ktt_pkg::NUM_CELLS];

    logic                              adv;
    logic                              accept;
    logic                              start;
    logic                              arm_sem;
    logic                              arm_task;
    logic                              any_fire;
    logic                              fire_task;
    logic [ktt_pkg::CHAN_W-1:0]        fire_chan;
    logic [ktt_pkg::VALUE_W-1:0]       rd_value;
    logic                              sem_ok;
    logic                              task_ok;

    logic                              n_load;
    logic [1:0]                        n_kind;
    logic [ktt_pkg::CHAN_W-1:0]        n_chan;
    logic [ktt_pkg::VALUE_W-1:0]       n_value;
    logic                              n_last;

    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && adv;
    assign accept     = i_in.valid && i_in.ready;
    assign sem_ok     = int'(i_in.channel) < ktt_pkg::NUM_SEMS;
    assign task_ok    = int'(i_in.channel) < ktt_pkg::NUM_TASKS;
    assign start      = accept && (i_in.cmd == ktt_pkg::CMD_TICK) && r_running;
    assign arm_sem    = accept && (i_in.cmd == ktt_pkg::CMD_ARM_SEM) && sem_ok;
    assign arm_task   = accept && (i_in.cmd == ktt_pkg::CMD_ARM_TASK) && task_ok;

    // cell chain: semaphore cells first, task cells after
    for (genvar g = 0; g < ktt_pkg::NUM_CELLS; g++) begin : g_cell
        logic tok_in;
        logic arm;
        if (g == 0) begin : g_head
            assign tok_in = start;
        end else begin : g_link
            assign tok_in = stat[g-1].tok;
        end
        if (g < ktt_pkg::NUM_SEMS) begin : g_sem
            assign arm = arm_sem && (int'(i_in.channel) == g);
        end else begin : g_task
            assign arm = arm_task && (int'(i_in.channel) == g - ktt_pkg::NUM_SEMS);
        end
        ktt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_tok     (tok_in),
            .i_is_task (g >= ktt_pkg::NUM_SEMS),
            .i_arm     (arm),
            .i_count   (i_in.count),
            .i_reload  (i_in.reload),
            .o_stat    (stat[g])
        );
    end

    // at most one cell holds the token, so at most one fires
    always_comb begin
        any_fire  = 1'b0;
        fire_task = 1'b0;
        fire_chan = '0;
        for (int i = 0; i < ktt_pkg::NUM_CELLS; i++) begin
            if (stat[i].fire) begin
                any_fire = 1'b1;
                if (i < ktt_pkg::NUM_SEMS) begin
                    fire_chan = fire_chan | ktt_pkg::CHAN_W'(i);
                end else begin
                    fire_task = 1'b1;
                    fire_chan = fire_chan | ktt_pkg::CHAN_W'(i - ktt_pkg::NUM_SEMS);
                end
            end
        end
    end

    always_comb begin
        rd_value = '0;
        for (int j = 0; j < ktt_pkg::NUM_TASKS; j++) begin
            if (int'(i_in.channel) == j) begin
                rd_value = stat[ktt_pkg::NUM_SEMS + j].value;
            end
        end
    end

    always_comb begin
        n_load  = 1'b0;
        n_kind  = ktt_pkg::KIND_TICK;
        n_chan  = '0;
        n_value = '0;
        n_last  = 1'b1;
        if (accept) begin
            n_chan = i_in.channel;
            case (i_in.cmd)
                ktt_pkg::CMD_TICK: begin
                    n_load = !r_running;
                    n_chan = '0;
                end
                ktt_pkg::CMD_ARM_SEM: begin
                    n_load  = 1'b1;
                    n_kind  = ktt_pkg::KIND_REPLY;
                    n_value = sem_ok ? {1'b0, i_in.count} : '0;
                end
                ktt_pkg::CMD_ARM_TASK: begin
                    n_load  = 1'b1;
                    n_kind  = ktt_pkg::KIND_REPLY;
                    n_value = task_ok ? {1'b0, i_in.count} : '0;
                end
                ktt_pkg::CMD_READ: begin
                    n_load  = 1'b1;
                    n_kind  = ktt_pkg::KIND_REPLY;
                    n_value = rd_value;
                end
                default: begin
                    n_load = 1'b0;
                end
            endcase
        end else if (r_state == ST_WALK && adv) begin
            if (any_fire) begin
                n_load  = 1'b1;
                n_kind  = fire_task ? ktt_pkg::KIND_TIMEOUT : ktt_pkg::KIND_SIGNAL;
                n_chan  = fire_chan;
                n_value = fire_task ? ktt_pkg::TIMED_OUT : '0;
                n_last  = 1'b0;
            end else if (r_tail) begin
                n_load = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= 1'b0;
            r_tick_size <= 8'd1;
            r_millis    <= '0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ktt_pkg::CFG_RUNNING:   r_running   <= i_cfg_data[0];
                    ktt_pkg::CFG_TICK_SIZE: r_tick_size <= i_cfg_data;
                    default: ;
                endcase
            end
            if (adv) begin
                r_tail <= stat[ktt_pkg::NUM_CELLS-1].tok;
            end
            if (start) begin
                r_millis <= r_millis + {{(ktt_pkg::MILLIS_W-ktt_pkg::TSIZE_W){1'b0}},
                                        r_tick_size};
                r_state  <= ST_WALK;
            end else if (r_state == ST_WALK && adv && r_tail) begin
                r_state <= ST_IDLE;
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_kind  <= n_kind;
            r_chan  <= n_chan;
            r_value <= n_value;
            r_last  <= n_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.event_channel = r_chan;
    assign o_out.timer_value   = r_value;
    assign o_out.millis        = r_millis;
    assign o_out.last          = r_last;

endmodule

@@ sv/ktt_chk.sv @@
// ----------------------------------------------------------------------------
// Kernel tick timer bank checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ktt_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [1:0]                        i_out_kind,
    input  logic [ktt_pkg::CHAN_W-1:0]        i_out_chan,
    input  logic [ktt_pkg::VALUE_W-1:0]       i_out_value,
    input  logic                              i_out_last
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_kind) && $stable(i_out_chan) &&
            $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled result changed");

    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == ktt_pkg::KIND_REPLY) |-> i_out_last)
        else $error("command reply without last");

    a_tick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == ktt_pkg::KIND_TICK) |->
            i_out_last && (i_out_chan == '0) && (i_out_value == '0))
        else $error("malformed tick-done result");

    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == ktt_pkg::KIND_TIMEOUT) |->
            !i_out_last && (i_out_value == ktt_pkg::TIMED_OUT))
        else $error("malformed timeout result");

endmodule

bind kernel_tick_timer_bank ktt_chk u_ktt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_chan  (o_out.event_channel),
    .i_out_value (o_out.timer_value),
    .i_out_last  (o_out.last)
);
